// ----- rtl/core/ict_pkg.sv -----
`timescale 1ns / 1ps

package ict_pkg;

	// mode codes on the func field
	localparam logic [1:0] FUNC_IPV4_HDR   = 2'd0;
	localparam logic [1:0] FUNC_TCP_V4     = 2'd1;
	localparam logic [1:0] FUNC_TCP_V6     = 2'd2;
	// bit 1 selects IPv6, so this code also runs TCP over IPv6
	localparam logic [1:0] FUNC_TCP_V6_ALT = 2'd3;

	// skipped checksum-field byte offsets and TCP minimum length
	localparam logic [31:0] IP_SKIP   = 32'd10;
	localparam logic [31:0] TCP_SKIP  = 32'd16;
	localparam logic [31:0] MIN_TCP   = 32'd18;
	localparam logic [15:0] PROTO_TCP = 16'd6;

	// front-to-back queue
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic [15:0] word;   // word completed by this byte
		logic        add;    // word is valid
		logic        last;
		logic        tcp;
		logic        v6;
		logic        pad_a;  // held address byte pads on last
		logic        pad_b;  // odd segment byte pads on last
		logic [7:0]  held;   // byte used for padding
		logic [31:0] cnt;    // segment byte count at this byte
	} ict_entry_t;

	// 16-bit ones'-complement add with end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

// ----- rtl/core/ict_in_if.sv -----
`timescale 1ns / 1ps

interface ict_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic       is_address;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output func, output is_address, output data_byte,
		output last, input ready);
	modport sink (input valid, input func, input is_address, input data_byte,
		input last, output ready);
endinterface

// ----- rtl/core/ict_out_if.sv -----
`timescale 1ns / 1ps

interface ict_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] checksum;
	logic        too_short;

	modport source (output valid, output checksum, output too_short, input ready);
	modport sink (input valid, input checksum, input too_short, output ready);
endinterface

// ----- rtl/core/internet_checksum_tcp_ip.sv -----
`timescale 1ns / 1ps

// Byte-serial Internet checksum: IPv4 header, TCP over IPv4, TCP over IPv6.
// pkt: one request per byte (func, is_address, data_byte, last), valid/ready.
//   For TCP, stream source/destination address bytes (is_address=1) first,
//   then the segment; checksum bytes of header/segment are skipped here.
// res: one request per packet (checksum, too_short), issued for the byte
//   marked last. TCP segments under 18 bytes return checksum 0, too_short 1.
// Throughput: one byte per cycle sustained while res is not stalled; the running
//   sum is a single 16-bit end-around add per byte in the back end.
// After the edge that takes the last byte, the result passes the queue, the
//   packet-sum stage, pad stage, pseudo-header stage and output register.
// A 4-entry queue parts the byte classifier from the summing pipeline.
// When res is stalled the back pipeline holds; pkt keeps taking bytes until
//   the queue fills, then ready drops.
// Reset clears the running sum, byte count, queue and pipeline valids; no
//   results are pending after reset and pkt is ready at once.
module internet_checksum_tcp_ip (
	input  logic      clk,
	input  logic      arst_n,
	ict_in_if.sink    pkt,
	ict_out_if.source res
);

	// front to queue
	logic                push_valid;
	logic                push_ready;
	ict_pkg::ict_entry_t push_entry;
	// queue to back
	logic                pop_valid;
	logic                pop_ready;
	ict_pkg::ict_entry_t pop_entry;

	// pairs bytes into words, tracks segment count and tail padding
	ict_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pkt        (pkt),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	ict_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	// accumulates words, then adds pads and pseudo-header and complements
	ict_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.res       (res)
	);

endmodule

// ----- rtl/core/ict_front.sv -----
`timescale 1ns / 1ps

module ict_front (
	input  logic                clk,
	input  logic                arst_n,
	ict_in_if.sink              pkt,
	output logic                push_valid,
	input  logic                push_ready,
	output ict_pkg::ict_entry_t push_entry
);

	logic [7:0]  held_q;
	logic [31:0] cnt_q;
	logic        aodd_q;

	logic [7:0]  held_n;
	logic [31:0] cnt_n;
	logic        aodd_n;
	logic        tcp;
	logic        v6;
	logic [31:0] base;
	logic        seg_skip;
	logic        tail_skip;
	logic [15:0] word;
	logic        add;
	logic        acc;

	assign pkt.ready  = push_ready;
	assign push_valid = pkt.valid;
	assign acc        = pkt.valid && push_ready;

	always_comb begin
		tcp      = pkt.func != ict_pkg::FUNC_IPV4_HDR;
		v6       = pkt.func[1];
		base     = tcp ? ict_pkg::TCP_SKIP : ict_pkg::IP_SKIP;
		seg_skip = (cnt_q == base) || (cnt_q == base + 32'd1);
		held_n   = held_q;
		cnt_n    = cnt_q;
		aodd_n   = aodd_q;
		word     = 16'd0;
		add      = 1'b0;
		if (pkt.is_address) begin
			// address bytes only count toward the TCP pseudo-header
			if (tcp) begin
				if (!aodd_q) begin
					held_n = pkt.data_byte;
					aodd_n = 1'b1;
				end else begin
					word   = {held_q, pkt.data_byte};
					add    = 1'b1;
					aodd_n = 1'b0;
				end
			end
		end else begin
			aodd_n = 1'b0;  // a dangling address byte is dropped
			if (!seg_skip) begin
				if (!cnt_q[0]) begin
					held_n = pkt.data_byte;
				end else begin
					word = {held_q, pkt.data_byte};
					add  = 1'b1;
				end
			end
			cnt_n = cnt_q + 32'd1;
		end
		tail_skip = (cnt_n == base + 32'd1) || (cnt_n == base + 32'd2);

		push_entry.word  = word;
		push_entry.add   = add;
		push_entry.last  = pkt.last;
		push_entry.tcp   = tcp;
		push_entry.v6    = v6;
		push_entry.pad_a = aodd_n;
		push_entry.pad_b = cnt_n[0] && !tail_skip;
		push_entry.held  = held_n;
		push_entry.cnt   = cnt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			cnt_q  <= '0;
			aodd_q <= 1'b0;
		end else if (acc) begin
			if (pkt.last) begin
				held_q <= '0;
				cnt_q  <= '0;
				aodd_q <= 1'b0;
			end else begin
				held_q <= held_n;
				cnt_q  <= cnt_n;
				aodd_q <= aodd_n;
			end
		end
	end

endmodule

// ----- rtl/core/ict_fifo.sv -----
`timescale 1ns / 1ps

module ict_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  ict_pkg::ict_entry_t push_entry,
	output logic                pop_valid,
	input  logic                pop_ready,
	output ict_pkg::ict_entry_t pop_entry
);

	ict_pkg::ict_entry_t mem [ict_pkg::FIFO_DEPTH];

	logic [ict_pkg::FIFO_AW-1:0] wr_q;
	logic [ict_pkg::FIFO_AW-1:0] rd_q;
	logic [ict_pkg::FIFO_AW:0]   cnt_q;
	logic                        push;
	logic                        pop;

	assign push_ready = cnt_q != (ict_pkg::FIFO_AW + 1)'(ict_pkg::FIFO_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_entry  = mem[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/ict_back.sv -----
`timescale 1ns / 1ps

module ict_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  ict_pkg::ict_entry_t pop_entry,
	ict_out_if.source           res
);

	logic        adv;
	logic        pop;
	logic [15:0] sum_q;
	logic [15:0] sum_acc;

	// stage 1: finished packet sum and tail info
	logic        vld_s1;
	logic [15:0] sum_s1;
	logic [7:0]  held_s1;
	logic        pad_a_s1;
	logic        pad_b_s1;
	logic        tl_s1;
	logic        v6_s1;
	logic [31:0] cnt_s1;
	logic        short_s1;
	// stage 2: pads added
	logic        vld_s2;
	logic [15:0] sum_s2;
	logic        tl_s2;
	logic        v6_s2;
	logic [31:0] cnt_s2;
	logic        short_s2;
	// stage 3: protocol and low length added
	logic        vld_s3;
	logic [15:0] sum_s3;
	logic        hi_s3;
	logic [15:0] len_hi_s3;
	logic        short_s3;
	// output register
	logic        vld_q;
	logic [15:0] chk_q;
	logic        short_q;

	logic        short_n;
	logic [15:0] pad_w;
	logic [15:0] sum2_n;
	logic [15:0] sum3_n;
	logic [15:0] fin_n;

	assign adv       = !vld_q || res.ready;
	assign pop_ready = adv;
	assign pop       = pop_valid && adv;

	assign res.valid     = vld_q;
	assign res.checksum  = chk_q;
	assign res.too_short = short_q;

	always_comb begin
		sum_acc = ict_pkg::oc_add(sum_q, pop_entry.add ? pop_entry.word : 16'd0);
		short_n = pop_entry.tcp && (pop_entry.cnt < ict_pkg::MIN_TCP);
		pad_w   = {held_s1, 8'd0};
		sum2_n  = ict_pkg::oc_add(ict_pkg::oc_add(sum_s1, pad_a_s1 ? pad_w : 16'd0),
			pad_b_s1 ? pad_w : 16'd0);
		sum3_n  = ict_pkg::oc_add(ict_pkg::oc_add(sum_s2, tl_s2 ? ict_pkg::PROTO_TCP : 16'd0),
			tl_s2 ? cnt_s2[15:0] : 16'd0);
		fin_n   = ict_pkg::oc_add(sum_s3, hi_s3 ? len_hi_s3 : 16'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (adv) begin
			if (pop) begin
				sum_q <= pop_entry.last ? 16'd0 : sum_acc;
			end
			vld_s1 <= pop && pop_entry.last;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_q  <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s1    <= sum_acc;
			held_s1   <= pop_entry.held;
			pad_a_s1  <= pop_entry.pad_a;
			pad_b_s1  <= pop_entry.pad_b;
			tl_s1     <= pop_entry.tcp && !short_n;
			v6_s1     <= pop_entry.v6;
			cnt_s1    <= pop_entry.cnt;
			short_s1  <= short_n;

			sum_s2    <= sum2_n;
			tl_s2     <= tl_s1;
			v6_s2     <= v6_s1;
			cnt_s2    <= cnt_s1;
			short_s2  <= short_s1;

			sum_s3    <= sum3_n;
			hi_s3     <= tl_s2 && v6_s2;
			len_hi_s3 <= cnt_s2[31:16];
			short_s3  <= short_s2;

			chk_q     <= short_s3 ? 16'd0 : ~fin_n;
			short_q   <= short_s3;
		end
	end

endmodule
